// ===== design/chse_pkg.sv =====
// ----------------------------------------------------------------------------
// chse_pkg
// Shared types, widths and constants of the closed spline evaluator.
// ----------------------------------------------------------------------------
package chse_pkg;

  localparam int MAX_POINTS = 32;
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int VAL_W      = 52;
  localparam int DIFF_W     = 33;
  localparam int S_W        = 17;
  localparam int K_W        = 17;

  localparam logic       OP_ADD  = 1'b0;
  localparam logic       OP_EVAL = 1'b1;

  localparam logic [2:0] ST_EVAL    = 3'd0;
  localparam logic [2:0] ST_ADDED   = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_TOO_FEW = 3'd3;
  localparam logic [2:0] ST_RANGE   = 3'd4;

  localparam logic signed [15:0] TENSION_RESET = -16'sd13107;

  typedef enum logic [1:0] {
    LIM_S = 2'd0,
    LIM_V = 2'd1,
    LIM_M = 2'd2,
    LIM_W = 2'd3
  } lim_sel_t;

  typedef struct packed {
    logic     start;
    lim_sel_t lim;
  } div_req_t;

  typedef struct packed {
    logic     start;
    logic     sh16;
    lim_sel_t lim;
  } mul_req_t;

  typedef struct packed {
    logic               op;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic        [31:0] time_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic        [2:0]  status;
  } out_item_t;

  function automatic logic [VAL_W-1:0] lim_value(input lim_sel_t sel);
    logic [VAL_W-1:0] v;
    case (sel)
      LIM_S:   v = VAL_W'(1) << 16;
      LIM_V:   v = VAL_W'(1) << 46;
      LIM_M:   v = VAL_W'(1) << 40;
      LIM_W:   v = VAL_W'(1) << 50;
      default: v = VAL_W'(1) << 50;
    endcase
    return v;
  endfunction

endpackage

// ===== design/closed_hermite_spline_eval.sv =====
// ----------------------------------------------------------------------------
// closed_hermite_spline_eval
// Point store and evaluator of a closed non-uniform cardinal spline.
// ----------------------------------------------------------------------------
// Command channel: an item transfers when start is high and busy is low.
// op selects add point or evaluate at time_value. Each item gives one
// result, shown for one cycle with done high; the receiver cannot stall.
// Config channel: cfg_valid/cfg_ready write tension; cfg_ready is always high.
// Points live in three single port RAMs (x, y, time).
// Sequence:
//   add to a full store, or evaluate with too few points: the status result
//     is given from the idle state
//   add: the new point is written (when the store is not empty, the old
//     closing point is first read and moved up)
//   evaluate: segment search over the time RAM, point reads, then 9
//     divisions and 16 multiplies on one divider and one multiplier. busy
//     stays high for the whole item.
// Reset clears the point count and loads the default tension; RAM contents
// are not cleared and are only read once written.
// ----------------------------------------------------------------------------
module closed_hermite_spline_eval
  import chse_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  in_item_t    cmd,
  output logic        done,
  output out_item_t   result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b00000001,
    S_ADD_RD = 8'b00000010,
    S_WR0    = 8'b00000100,
    S_WR1    = 8'b00001000,
    S_SRCH   = 8'b00010000,
    S_RD     = 8'b00100000,
    S_ISSUE  = 8'b01000000,
    S_WAIT   = 8'b10000000
  } state_t;

  localparam logic [3:0] STEP_S   = 4'd0;
  localparam logic [3:0] STEP_S2  = 4'd1;
  localparam logic [3:0] STEP_S3  = 4'd2;
  localparam logic [3:0] STEP_QA0 = 4'd3;
  localparam logic [3:0] STEP_QB0 = 4'd4;
  localparam logic [3:0] STEP_V0  = 4'd5;
  localparam logic [3:0] STEP_QA1 = 4'd6;
  localparam logic [3:0] STEP_QB1 = 4'd7;
  localparam logic [3:0] STEP_V1  = 4'd8;
  localparam logic [3:0] STEP_M0  = 4'd9;
  localparam logic [3:0] STEP_M1  = 4'd10;
  localparam logic [3:0] STEP_T1  = 4'd11;
  localparam logic [3:0] STEP_T2  = 4'd12;
  localparam logic [3:0] STEP_T3  = 4'd13;
  localparam logic [3:0] STEP_SUM = 4'd14;

  localparam logic [31:0] HALF_SEC = 32'h0000_8000;

  state_t                   state;
  logic [CNT_W-1:0]         pcount;
  logic signed [15:0]       tension;
  in_item_t                 cmd_r;
  logic [ADDR_W-1:0]        seg;
  logic [CNT_W-1:0]         j;
  logic [CNT_W-1:0]         ridx;
  logic                     rv;
  logic [31:0]              tprev;
  logic [2:0]               rk;
  logic [31:0]              tt [5];
  logic signed [31:0]       px [4];
  logic signed [31:0]       py [4];
  logic [3:0]               step;
  logic                     axis;
  logic [S_W-1:0]           s;
  logic [S_W-1:0]           s2;
  logic [S_W-1:0]           s3;
  logic signed [47:0]       qa;
  logic signed [47:0]       qb;
  logic signed [47:0]       v0;
  logic signed [47:0]       v1;
  logic signed [41:0]       m0;
  logic signed [41:0]       m1;
  logic signed [VAL_W-1:0]  t1;
  logic signed [VAL_W-1:0]  t2;
  logic signed [VAL_W-1:0]  t3;
  logic signed [31:0]       res_x;

  logic [ADDR_W-1:0] ram_addr;
  logic              xy_we;
  logic              t_we;
  logic [31:0]       wx;
  logic [31:0]       wy;
  logic [31:0]       wt;
  logic [31:0]       rx;
  logic [31:0]       ry;
  logic [31:0]       rt;

  mul_req_t                mreq;
  div_req_t                dreq;
  logic signed [VAL_W-1:0] mul_a;
  logic signed [VAL_W-1:0] mul_b;
  logic signed [DIFF_W-1:0] div_num;
  logic signed [DIFF_W-1:0] div_den;
  logic                    mul_done;
  logic                    div_done;
  logic signed [VAL_W-1:0] mul_res;
  logic signed [VAL_W-1:0] div_res;
  logic                    use_div;
  logic                    unit_done;
  logic signed [VAL_W-1:0] unit_res;

  logic              empty;
  logic [31:0]       tc;
  logic              first;
  logic              last;
  logic [CNT_W-1:0]  seg_c;
  logic [CNT_W-1:0]  ia;
  logic [CNT_W-1:0]  ib;
  logic [CNT_W-1:0]  ic;
  logic [CNT_W-1:0]  id;
  logic [CNT_W-1:0]  rd_idx;
  logic              hit;
  logic [DIFF_W-1:0] d_ab;
  logic [DIFF_W-1:0] d_bc;
  logic [DIFF_W-1:0] d_cd;
  logic [DIFF_W-1:0] u;
  logic signed [31:0] pa;
  logic signed [31:0] pb;
  logic signed [31:0] pc;
  logic signed [31:0] pd;
  logic signed [DIFF_W-1:0] dba;
  logic signed [DIFF_W-1:0] dcb;
  logic signed [DIFF_W-1:0] ddc;
  logic signed [K_W-1:0]    kscale;
  logic signed [VAL_W-1:0]  qsum;
  logic signed [VAL_W-1:0]  dv;
  logic signed [VAL_W-1:0]  c2;
  logic signed [VAL_W-1:0]  c3;
  logic signed [53:0]       acc;
  logic signed [31:0]       acc_sat;

  chse_ram #(.W(32), .DEPTH(MAX_POINTS)) u_ram_x (
    .clk(clk), .we(xy_we), .addr(ram_addr), .wdata(wx), .rdata(rx)
  );
  chse_ram #(.W(32), .DEPTH(MAX_POINTS)) u_ram_y (
    .clk(clk), .we(xy_we), .addr(ram_addr), .wdata(wy), .rdata(ry)
  );
  chse_ram #(.W(32), .DEPTH(MAX_POINTS)) u_ram_t (
    .clk(clk), .we(t_we), .addr(ram_addr), .wdata(wt), .rdata(rt)
  );

  chse_mul u_mul (
    .clk(clk), .rst(rst), .req(mreq), .a(mul_a), .b(mul_b),
    .done(mul_done), .result(mul_res)
  );
  chse_div u_div (
    .clk(clk), .rst(rst), .req(dreq), .num(div_num), .den(div_den),
    .done(div_done), .result(div_res)
  );

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  assign empty = (pcount == '0);
  assign tc    = (cmd_r.time_value > (32'hFFFF_FFFF - HALF_SEC)) ? 32'hFFFF_FFFF
               : cmd_r.time_value + HALF_SEC;

  // segment neighbor indices, wrapping through the closing point
  assign seg_c = CNT_W'(seg);
  assign first = (seg == '0);
  assign last  = (seg_c == pcount - CNT_W'(2));
  assign ia = first ? pcount - CNT_W'(2) : last ? pcount - CNT_W'(3) : seg_c - CNT_W'(1);
  assign ib = first ? pcount - CNT_W'(1) : seg_c;
  assign ic = first ? CNT_W'(1) : seg_c + CNT_W'(1);
  assign id = first ? CNT_W'(2) : last ? CNT_W'(1) : seg_c + CNT_W'(2);

  always_comb begin
    case (rk)
      3'd0:    rd_idx = ia;
      3'd1:    rd_idx = ib;
      3'd2:    rd_idx = ic;
      3'd3:    rd_idx = id;
      default: rd_idx = '0;
    endcase
  end

  assign hit = rv && (ridx != '0) && (tprev <= cmd_r.time_value) && (cmd_r.time_value <= rt);

  // tt: A, B, C, D, point 0
  assign d_ab = {1'b0, tt[1]} - {1'b0, tt[0]};
  assign d_bc = first ? {1'b0, tt[2]} - {1'b0, tt[4]} : {1'b0, tt[2]} - {1'b0, tt[1]};
  assign d_cd = last  ? {1'b0, tt[3]} - {1'b0, tt[4]} : {1'b0, tt[3]} - {1'b0, tt[2]};
  assign u    = {1'b0, cmd_r.time_value} - {1'b0, (first ? tt[4] : tt[1])};

  assign pa = axis ? py[0] : px[0];
  assign pb = axis ? py[1] : px[1];
  assign pc = axis ? py[2] : px[2];
  assign pd = axis ? py[3] : px[3];
  assign dba = DIFF_W'(pb) - DIFF_W'(pa);
  assign dcb = DIFF_W'(pc) - DIFF_W'(pb);
  assign ddc = DIFF_W'(pd) - DIFF_W'(pc);

  assign kscale = K_W'(16384) - K_W'(tension);
  assign qsum   = VAL_W'(qa) + VAL_W'(qb);
  assign dv     = VAL_W'(dcb);
  assign c2     = (dv <<< 1) + dv - (VAL_W'(m0) <<< 1) - VAL_W'(m1);
  assign c3     = VAL_W'(m0) + VAL_W'(m1) - (dv <<< 1);

  assign acc = 54'(pb) + 54'(t1) + 54'(t2) + 54'(t3);
  assign acc_sat = (acc > 54'sd2147483647) ? 32'sh7FFF_FFFF
                 : (acc < -54'sd2147483648) ? 32'sh8000_0000 : acc[31:0];

  always_comb begin
    use_div  = 1'b0;
    mul_a    = '0;
    mul_b    = '0;
    div_num  = '0;
    div_den  = '0;
    mreq     = '{start: 1'b0, sh16: 1'b1, lim: LIM_W};
    dreq     = '{start: 1'b0, lim: LIM_V};
    case (step)
      STEP_S: begin
        use_div = 1'b1; div_num = u; div_den = d_bc; dreq.lim = LIM_S;
      end
      STEP_S2: begin
        mul_a = VAL_W'(s); mul_b = VAL_W'(s); mreq.lim = LIM_S;
      end
      STEP_S3: begin
        mul_a = VAL_W'(s2); mul_b = VAL_W'(s); mreq.lim = LIM_S;
      end
      STEP_QA0: begin
        use_div = 1'b1; div_num = dcb; div_den = d_bc;
      end
      STEP_QB0: begin
        use_div = 1'b1; div_num = dba; div_den = d_ab;
      end
      STEP_QA1: begin
        use_div = 1'b1; div_num = ddc; div_den = d_cd;
      end
      STEP_QB1: begin
        use_div = 1'b1; div_num = dcb; div_den = d_bc;
      end
      STEP_V0, STEP_V1: begin
        mul_a = qsum; mul_b = VAL_W'(kscale); mreq.sh16 = 1'b0; mreq.lim = LIM_V;
      end
      STEP_M0: begin
        mul_a = VAL_W'($signed(d_bc)); mul_b = VAL_W'(v0); mreq.lim = LIM_M;
      end
      STEP_M1: begin
        mul_a = VAL_W'($signed(d_bc)); mul_b = VAL_W'(v1); mreq.lim = LIM_M;
      end
      STEP_T1: begin
        mul_a = VAL_W'(m0); mul_b = VAL_W'(s);
      end
      STEP_T2: begin
        mul_a = c2; mul_b = VAL_W'(s2);
      end
      STEP_T3: begin
        mul_a = c3; mul_b = VAL_W'(s3);
      end
      default: begin
        use_div = 1'b0;
      end
    endcase
    if (state == S_ISSUE && step != STEP_SUM) begin
      if (use_div) begin
        dreq.start = 1'b1;
      end else begin
        mreq.start = 1'b1;
      end
    end
  end

  assign unit_done = use_div ? div_done : mul_done;
  assign unit_res  = use_div ? div_res : mul_res;

  always_comb begin
    ram_addr = '0;
    xy_we    = 1'b0;
    t_we     = 1'b0;
    wx       = cmd_r.coord_x;
    wy       = cmd_r.coord_y;
    wt       = cmd_r.time_value;
    case (state)
      S_ADD_RD: begin
        ram_addr = ADDR_W'(pcount - CNT_W'(1));
      end
      S_WR0: begin
        xy_we = 1'b1;
        t_we  = 1'b1;
        if (empty) begin
          ram_addr = '0;
        end else begin
          ram_addr = ADDR_W'(pcount);
          wx       = rx;
          wy       = ry;
          wt       = tc;
        end
      end
      S_WR1: begin
        xy_we = 1'b1;
        t_we  = 1'b1;
        if (empty) begin
          ram_addr = ADDR_W'(1);
          wt       = tc;
        end else begin
          ram_addr = ADDR_W'(pcount - CNT_W'(1));
        end
      end
      S_SRCH: begin
        ram_addr = j[ADDR_W-1:0];
      end
      S_RD: begin
        ram_addr = rd_idx[ADDR_W-1:0];
      end
      default: begin
        ram_addr = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      pcount  <= '0;
      tension <= TENSION_RESET;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        tension <= $signed(cfg_data);
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            cmd_r <= cmd;
            if (cmd.op == OP_ADD) begin
              if (pcount >= CNT_W'(MAX_POINTS)) begin
                result <= '{out_x: '0, out_y: '0, status: ST_FULL};
                done   <= 1'b1;
              end else if (empty) begin
                state <= S_WR0;
              end else begin
                state <= S_ADD_RD;
              end
            end else if (pcount < CNT_W'(4)) begin
              result <= '{out_x: '0, out_y: '0, status: ST_TOO_FEW};
              done   <= 1'b1;
            end else begin
              j     <= '0;
              rv    <= 1'b0;
              state <= S_SRCH;
            end
          end
        end
        S_ADD_RD: begin
          state <= S_WR0;
        end
        S_WR0: begin
          state <= S_WR1;
        end
        S_WR1: begin
          pcount <= empty ? CNT_W'(2) : pcount + CNT_W'(1);
          result <= '{out_x: '0, out_y: '0, status: ST_ADDED};
          done   <= 1'b1;
          state  <= S_IDLE;
        end
        S_SRCH: begin
          j    <= j + CNT_W'(1);
          ridx <= j;
          rv   <= 1'b1;
          if (rv) begin
            tprev <= rt;
          end
          if (hit) begin
            seg   <= ADDR_W'(ridx - CNT_W'(1));
            rk    <= '0;
            state <= S_RD;
          end else if (rv && ridx == pcount - CNT_W'(1)) begin
            result <= '{out_x: '0, out_y: '0, status: ST_RANGE};
            done   <= 1'b1;
            state  <= S_IDLE;
          end
        end
        S_RD: begin
          rk <= rk + 3'd1;
          if (rk != '0) begin
            tt[rk - 3'd1] <= rt;
            if (rk != 3'd5) begin
              px[2'(rk - 3'd1)] <= rx;
              py[2'(rk - 3'd1)] <= ry;
            end
          end
          if (rk == 3'd5) begin
            step  <= STEP_S;
            axis  <= 1'b0;
            state <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          if (step == STEP_SUM) begin
            if (!axis) begin
              res_x <= acc_sat;
              axis  <= 1'b1;
              step  <= STEP_QA0;
            end else begin
              result <= '{out_x: res_x, out_y: acc_sat, status: ST_EVAL};
              done   <= 1'b1;
              state  <= S_IDLE;
            end
          end else begin
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (unit_done) begin
            case (step)
              STEP_S:   s  <= unit_res[S_W-1:0];
              STEP_S2:  s2 <= unit_res[S_W-1:0];
              STEP_S3:  s3 <= unit_res[S_W-1:0];
              STEP_QA0: qa <= unit_res[47:0];
              STEP_QA1: qa <= unit_res[47:0];
              STEP_QB0: qb <= unit_res[47:0];
              STEP_QB1: qb <= unit_res[47:0];
              STEP_V0:  v0 <= unit_res[47:0];
              STEP_V1:  v1 <= unit_res[47:0];
              STEP_M0:  m0 <= unit_res[41:0];
              STEP_M1:  m1 <= unit_res[41:0];
              STEP_T1:  t1 <= unit_res;
              STEP_T2:  t2 <= unit_res;
              STEP_T3:  t3 <= unit_res;
              default:  t3 <= unit_res;
            endcase
            step  <= step + 4'd1;
            state <= S_ISSUE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    pcount <= CNT_W'(MAX_POINTS))
    else $error("point count beyond store size");

  a_busy_ends_with_result: assert property (@(posedge clk) disable iff (rst)
    ($fell(busy) && !$past(rst)) |-> done)
    else $error("item finished without a result");

  a_one_unit_at_a_time: assert property (@(posedge clk) disable iff (rst)
    !(mul_done && div_done))
    else $error("multiplier and divider finished together");

  a_no_start_while_waiting: assert property (@(posedge clk) disable iff (rst)
    (state == S_WAIT) |-> !(mreq.start || dreq.start))
    else $error("arithmetic start while waiting on a unit");
`endif

endmodule

// ===== design/chse_ram.sv =====
// ----------------------------------------------------------------------------
// chse_ram
// Single port synchronous RAM, registered read.
// ----------------------------------------------------------------------------
module chse_ram #(
  parameter int W     = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [W-1:0]             wdata,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== design/chse_div.sv =====
// ----------------------------------------------------------------------------
// chse_div
// Restoring divider: round(num * 2^16 / den), saturated, zero divisor gives 0.
// ----------------------------------------------------------------------------
module chse_div
  import chse_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  div_req_t                req,
  input  logic signed [DIFF_W-1:0] num,
  input  logic signed [DIFF_W-1:0] den,
  output logic                    done,
  output logic signed [VAL_W-1:0] result
);

  localparam int MAG_W = DIFF_W;
  localparam int QN_W  = MAG_W + 17;
  localparam int CW    = $clog2(QN_W);

  typedef enum logic [2:0] {
    D_IDLE = 3'b001,
    D_RUN  = 3'b010,
    D_SAT  = 3'b100
  } dstate_t;

  dstate_t          state;
  logic [CW-1:0]    cnt;
  logic [QN_W-1:0]  dq;
  logic [MAG_W-1:0] rem;
  logic [MAG_W-1:0] ud;
  logic             neg;
  logic             zero;
  lim_sel_t         lim;

  logic [MAG_W-1:0] un_in;
  logic [MAG_W-1:0] ud_in;
  logic [MAG_W:0]   trial;
  logic             ge;
  logic [MAG_W:0]   diff;
  logic [QN_W-1:0]  lim_ext;
  logic [VAL_W-1:0] qsat;

  assign un_in   = num[DIFF_W-1] ? MAG_W'(-num) : MAG_W'(num);
  assign ud_in   = den[DIFF_W-1] ? MAG_W'(-den) : MAG_W'(den);
  assign trial   = {rem, dq[QN_W-1]};
  assign ge      = trial >= {1'b0, ud};
  assign diff    = trial - {1'b0, ud};
  assign lim_ext = QN_W'(lim_value(lim));
  assign qsat    = (dq > lim_ext) ? lim_value(lim) : VAL_W'(dq);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        D_IDLE: begin
          if (req.start) begin
            dq    <= (QN_W'(un_in) << 16) + QN_W'(ud_in >> 1);
            rem   <= '0;
            ud    <= ud_in;
            zero  <= (ud_in == '0);
            neg   <= num[DIFF_W-1] ^ den[DIFF_W-1];
            lim   <= req.lim;
            cnt   <= CW'(QN_W - 1);
            state <= D_RUN;
          end
        end
        D_RUN: begin
          rem <= ge ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
          dq  <= {dq[QN_W-2:0], ge};
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= D_SAT;
          end
        end
        D_SAT: begin
          if (zero) begin
            result <= '0;
          end else begin
            result <= neg ? -$signed(qsat) : $signed(qsat);
          end
          done  <= 1'b1;
          state <= D_IDLE;
        end
        default: state <= D_IDLE;
      endcase
    end
  end

endmodule

// ===== design/chse_mul.sv =====
// ----------------------------------------------------------------------------
// chse_mul
// Shift-add multiplier: round(a * b / 2^sh), sh 15 or 16, saturated.
// ----------------------------------------------------------------------------
module chse_mul
  import chse_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  mul_req_t                req,
  input  logic signed [VAL_W-1:0] a,
  input  logic signed [VAL_W-1:0] b,
  output logic                    done,
  output logic signed [VAL_W-1:0] result
);

  localparam int MW = VAL_W;
  localparam int PW = 2 * MW;
  localparam int CW = $clog2(MW);

  typedef enum logic [3:0] {
    M_IDLE = 4'b0001,
    M_RUN  = 4'b0010,
    M_RND  = 4'b0100,
    M_SAT  = 4'b1000
  } mstate_t;

  mstate_t       state;
  logic [CW-1:0] cnt;
  logic [PW-1:0] prod;
  logic [MW-1:0] ma;
  logic [PW:0]   mag;
  logic          neg;
  logic          sh16;
  lim_sel_t      lim;

  logic [MW:0]      psum;
  logic [PW:0]      rsum;
  logic [VAL_W-1:0] msat;

  assign psum = {1'b0, prod[PW-1:MW]} + (prod[0] ? {1'b0, ma} : '0);
  assign rsum = {1'b0, prod} + (sh16 ? ((PW+1)'(1) << 15) : ((PW+1)'(1) << 14));
  assign msat = (mag > (PW+1)'(lim_value(lim))) ? lim_value(lim) : mag[VAL_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        M_IDLE: begin
          if (req.start) begin
            ma    <= a[VAL_W-1] ? MW'(-a) : MW'(a);
            prod  <= {{MW{1'b0}}, (b[VAL_W-1] ? MW'(-b) : MW'(b))};
            neg   <= a[VAL_W-1] ^ b[VAL_W-1];
            sh16  <= req.sh16;
            lim   <= req.lim;
            cnt   <= CW'(MW - 1);
            state <= M_RUN;
          end
        end
        M_RUN: begin
          prod <= {psum, prod[MW-1:1]};
          cnt  <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= M_RND;
          end
        end
        M_RND: begin
          mag   <= sh16 ? (rsum >> 16) : (rsum >> 15);
          state <= M_SAT;
        end
        M_SAT: begin
          result <= neg ? -$signed(msat) : $signed(msat);
          done   <= 1'b1;
          state  <= M_IDLE;
        end
        default: state <= M_IDLE;
      endcase
    end
  end

endmodule
